[rtl/cascaded_range_remap_min_core_macros.svh]
// assertion helpers shared by the rtl
`ifndef CASCADED_RANGE_REMAP_MIN_CORE_MACROS_SVH
`define CASCADED_RANGE_REMAP_MIN_CORE_MACROS_SVH

// same-cycle implication
`define CRRM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRRM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/crrm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package crrm_pkg;

	localparam int VALUE_BITS  = 40;
	localparam int STAGE_BITS  = 3;
	localparam int DEF_STAGES  = 7;
	localparam int DEF_ENTRIES = 64;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_XLATE  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]            func;
		logic [STAGE_BITS-1:0] stage;
		logic [VALUE_BITS-1:0] dest_start;
		logic [VALUE_BITS-1:0] src_start;
		logic [VALUE_BITS-1:0] span;
		logic [VALUE_BITS-1:0] seed_value;
	} req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] location;
		logic [VALUE_BITS-1:0] lowest;
		logic                  status;
	} rsp_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] lo;
		logic [VALUE_BITS:0]   hi;
		logic [VALUE_BITS:0]   shift;
	} entry_t;

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] value;
	} match_t;

endpackage

`default_nettype wire

[rtl/crrm_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module crrm_table
	import crrm_pkg::*;
#(
	parameter int DEPTH  = DEF_STAGES * DEF_ENTRIES,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  entry_t                wr_entry,
	input  logic [ADDR_W-1:0]     rd_addr,
	input  logic [VALUE_BITS-1:0] value,
	output match_t                match
);

	entry_t              mem [DEPTH];
	entry_t              rd_q;
	logic [VALUE_BITS:0] sum;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// half-open range check and offset add, saturating
	always_comb begin
		sum         = {1'b0, value} + rd_q.shift;
		match.hit   = (value >= rd_q.lo) && ({1'b0, value} < rd_q.hi);
		match.value = sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
	end

endmodule

`default_nettype wire

[rtl/cascaded_range_remap_min_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Cascaded range remap with running minimum.
// Request channel (req_valid/req_ready/req) carries load, translate and clear
// requests; response channel (rsp_valid/rsp_ready/rsp) returns exactly one
// response per request, in order.
// req_ready is high only while the sequencer is idle; one request is worked
// at a time. A finished response sits in the output register, so the next
// request is taken while the previous response still waits.
// Load, clear and unknown requests pass S_EXEC, then S_DONE sets rsp_valid.
// Translate: each stage scans its entries one per cycle through the single
// table read port and the shared range compare/add unit. A stage ends at its
// first matching entry or after its last entry.
// A new request can be taken in the cycle after rsp_valid rises.
// Reset empties every stage (entry counts to zero) and sets the minimum to
// all ones; table contents are not cleared and are never read past a count.
// When rsp_ready is low, the response is held and the sequencer waits in its
// final state with the next result until the output register frees up.
`include "cascaded_range_remap_min_core_macros.svh"

module cascaded_range_remap_min_core
	import crrm_pkg::*;
#(
	parameter int STAGES  = DEF_STAGES,
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int DEPTH   = STAGES * ENTRIES;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOOK,
		S_DONE
	} state_t;

	state_t                state_q;
	req_t                  req_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic [CNT_W-1:0]      count_q [STAGES];
	logic [VALUE_BITS-1:0] lowest_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] loc_q;
	logic                  status_q;
	logic [STAGE_W-1:0]    stage_q;
	logic [ADDR_W-1:0]     base_q;
	logic [CNT_W-1:0]      entry_q;
	logic                  pend_q;

	logic [STAGE_W+STAGE_BITS-1:0] stage_wide;
	logic                          stage_ok;
	logic [STAGE_W-1:0]            cnt_idx;
	logic [CNT_W-1:0]              cnt_rd;
	logic                          load_ok;
	logic                          wr_en;
	logic [ADDR_W-1:0]             wr_addr;
	entry_t                        wr_entry;
	logic [ADDR_W-1:0]             rd_addr;
	match_t                        m;
	logic                          hit;
	logic                          adv;
	logic [VALUE_BITS-1:0]         v_adv;
	logic [VALUE_BITS-1:0]         lowest_nx;
	logic                          out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		stage_wide = {{STAGE_W{1'b0}}, req_q.stage};
		stage_ok   = 32'(req_q.stage) < STAGES;
		if (state_q == S_LOOK) begin
			cnt_idx = stage_q;
		end else if (stage_ok) begin
			cnt_idx = stage_wide[STAGE_W-1:0];
		end else begin
			cnt_idx = '0;
		end
		cnt_rd  = count_q[cnt_idx];
		load_ok = stage_ok && (cnt_rd < CNT_W'(ENTRIES));

		wr_en          = (state_q == S_EXEC) && (req_q.func == FUNC_LOAD) && load_ok;
		wr_addr        = ADDR_W'(cnt_idx) * ADDR_W'(ENTRIES) + ADDR_W'(cnt_rd);
		wr_entry.lo    = req_q.src_start;
		wr_entry.hi    = {1'b0, req_q.src_start} + {1'b0, req_q.span};
		wr_entry.shift = {1'b0, req_q.dest_start} - {1'b0, req_q.src_start};

		rd_addr = base_q + ADDR_W'(entry_q);
		hit     = pend_q && m.hit;
		adv     = hit || (entry_q >= cnt_rd);
		v_adv   = hit ? m.value : v_q;

		if ((req_q.func == FUNC_XLATE) && (loc_q < lowest_q)) begin
			lowest_nx = loc_q;
		end else begin
			lowest_nx = lowest_q;
		end
		out_free = !rsp_valid_q || rsp_ready;
	end

	crrm_table #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_addr  (rd_addr),
		.value    (v_q),
		.match    (m)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < STAGES; i++) begin
				count_q[i] <= '0;
			end
			lowest_q <= {VALUE_BITS{1'b1}};
			v_q      <= '0;
			loc_q    <= '0;
			status_q <= 1'b0;
			stage_q  <= '0;
			base_q   <= '0;
			entry_q  <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					loc_q    <= '0;
					status_q <= (req_q.func == FUNC_LOAD) && !load_ok;
					if (req_q.func == FUNC_XLATE) begin
						state_q <= S_LOOK;
					end else begin
						state_q <= S_DONE;
					end
					case (req_q.func)
						FUNC_LOAD: begin
							if (load_ok) begin
								count_q[cnt_idx] <= cnt_rd + 1'b1;
							end
						end
						FUNC_XLATE: begin
							v_q     <= req_q.seed_value;
							stage_q <= '0;
							base_q  <= '0;
							entry_q <= '0;
							pend_q  <= 1'b0;
						end
						FUNC_CLEAR: begin
							for (int i = 0; i < STAGES; i++) begin
								count_q[i] <= '0;
							end
							lowest_q <= {VALUE_BITS{1'b1}};
						end
						default: begin
						end
					endcase
				end
				S_LOOK: begin
					if (adv) begin
						v_q     <= v_adv;
						entry_q <= '0;
						pend_q  <= 1'b0;
						if (stage_q == STAGE_W'(STAGES - 1)) begin
							loc_q   <= v_adv;
							state_q <= S_DONE;
						end else begin
							stage_q <= stage_q + 1'b1;
							base_q  <= base_q + ADDR_W'(ENTRIES);
						end
					end else begin
						// issue next entry read
						entry_q <= entry_q + 1'b1;
						pend_q  <= 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_q.location <= loc_q;
						rsp_q.lowest   <= lowest_nx;
						rsp_q.status   <= status_q;
						lowest_q       <= lowest_nx;
						rsp_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CRRM_ASSERT_IMP(a_count_bound, 1'b1, cnt_rd <= CNT_W'(ENTRIES), "stage count above capacity")
	`CRRM_ASSERT_IMP(a_pend_look, pend_q, state_q == S_LOOK, "pending read outside scan")
	`CRRM_ASSERT_IMP(a_entry_bound, state_q == S_LOOK, entry_q <= cnt_rd, "scan past stage count")
	`CRRM_ASSERT_NXT(a_issue_pend, (state_q == S_LOOK) && !adv, pend_q && (state_q == S_LOOK), "issued read not checked")
	`CRRM_ASSERT_IMP(a_drop_zero, rsp_valid && rsp.status, rsp.location == '0, "dropped load with location")

endmodule

`default_nettype wire
